>>> rtl/abs_dx_pkg.sv
// Shared types and constants for the absolute horizontal gradient column-sum unit.
// No dependencies; every file in rtl/ except abs_dx_ram imports this package.
package abs_dx_pkg;

    // Fixed field widths.
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 24;
    localparam int IMG_W_W    = 13;
    localparam int IMG_H_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Depth of the queue between front and back, and of the result buffer.
    localparam int QUEUE_DEPTH = 2;
    localparam int RES_DEPTH   = 4;

    // Classification of one pixel, made by the front at acceptance.
    typedef struct packed {
        logic has_col;    // pixel closes a difference for column x-1
        logic first_row;  // first row of the frame: store is written, not added to
        logic last_row;   // last row of the frame: final sums are emitted
        logic last_col;   // pixel ends its row
    } abs_dx_flags_t;

    // Status of the front-to-back queue.
    typedef struct packed {
        logic full;
        logic empty;
    } abs_dx_qstat_t;

endpackage

>>> rtl/abs_dx_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by the back end for the column store.
module abs_dx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/abs_dx_front.sv
// Front end: accepts pixels, tracks column and row position and classifies each pixel.
// Depends on abs_dx_pkg; feeds abs_dx_queue.
module abs_dx_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [abs_dx_pkg::PIX_W-1:0]        pixel,
    input  logic [abs_dx_pkg::IMG_W_W-1:0]      image_width,
    input  logic [abs_dx_pkg::IMG_H_W-1:0]      image_height,
    input  abs_dx_pkg::abs_dx_qstat_t           q_stat,
    output logic                                q_push,
    output abs_dx_pkg::abs_dx_flags_t           item_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]        item_x,
    output logic [abs_dx_pkg::PIX_W-1:0]        item_diff
);

    import abs_dx_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0]   prev_pixel_reg;
    logic [PIX_W-1:0]   prev_pixel_next;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [IMG_H_W-1:0] row_reg;
    logic [IMG_H_W-1:0] row_next;
    logic [CW-1:0]      width_m1;
    logic [IMG_H_W-1:0] height_m1;
    logic               accept;

    // Last column and last row indexes, with zero read as one and width clamped.
    always_comb
    begin
        if (image_width == '0)
        begin
            width_m1 = '0;
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            width_m1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = CW'(32'(image_width) - 32'd1);
        end
        height_m1 = (image_height == '0) ? '0 : image_height - IMG_H_W'(1);
    end

    // The request is taken whenever the queue has room.
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign q_push   = accept;

    // Classify the pixel and form the absolute difference to its left neighbor.
    always_comb
    begin
        item_flags.has_col   = (col_reg != '0);
        item_flags.first_row = (row_reg == '0);
        item_flags.last_row  = (row_reg >= height_m1);
        item_flags.last_col  = (col_reg >= width_m1);
        item_x               = col_reg;
        item_diff            = (pixel > prev_pixel_reg) ? pixel - prev_pixel_reg
                                                        : prev_pixel_reg - pixel;
    end

    // Position update: a row ends at the last column, the frame at the last row.
    always_comb
    begin
        prev_pixel_next = prev_pixel_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        if (accept)
        begin
            prev_pixel_next = pixel;
            if (item_flags.last_col)
            begin
                col_next = '0;
                row_next = item_flags.last_row ? '0 : row_reg + IMG_H_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pixel_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            prev_pixel_reg <= prev_pixel_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
        end
    end

endmodule

>>> rtl/abs_dx_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on abs_dx_pkg for its depth and status type.
module abs_dx_queue #(
    parameter int DW = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [DW-1:0]             push_data,
    input  logic                      pop,
    output logic [DW-1:0]             pop_data,
    output abs_dx_pkg::abs_dx_qstat_t stat
);

    import abs_dx_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] data_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    assign stat.full  = (count_reg == NW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = data_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/abs_dx_back.sv
// Back end: read-modify-write of the column store and buffering of the result requests.
// Depends on abs_dx_pkg and abs_dx_ram.
module abs_dx_back #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  abs_dx_pkg::abs_dx_qstat_t       q_stat,
    input  abs_dx_pkg::abs_dx_flags_t       head_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]    head_x,
    input  logic [abs_dx_pkg::PIX_W-1:0]    head_diff,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]    column_index,
    output logic [abs_dx_pkg::SUM_W-1:0]    column_sum,
    output logic                            last
);

    import abs_dx_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RP = $clog2(RES_DEPTH);
    localparam int RN = $clog2(RES_DEPTH + 1);

    // Execute stage holding the item whose store word is being read.
    logic            ex_valid_reg;
    logic            ex_valid_next;
    abs_dx_flags_t   ex_flags_reg;
    logic [CW-1:0]   ex_x_reg;
    logic [PIX_W-1:0] ex_diff_reg;

    logic            load;
    logic            advance;
    logic            emit_sum;
    logic            emit_zero;
    logic [1:0]      n_res;
    logic [RN-1:0]   res_free;
    logic [SUM_W-1:0] store_rd;
    logic [SUM_W-1:0] new_sum;
    logic [CW-1:0]   ex_col;

    // Result buffer.
    logic [CW-1:0]    res_idx_reg  [RES_DEPTH];
    logic [SUM_W-1:0] res_sum_reg  [RES_DEPTH];
    logic             res_last_reg [RES_DEPTH];
    logic [RP-1:0]    res_wr_reg;
    logic [RP-1:0]    res_wr_next;
    logic [RP-1:0]    res_rd_reg;
    logic [RP-1:0]    res_rd_next;
    logic [RN-1:0]    res_cnt_reg;
    logic [RN-1:0]    res_cnt_next;
    logic             res_pop;
    logic [CW-1:0]    r0_idx;
    logic [SUM_W-1:0] r0_sum;
    logic             r0_last;

    // Results this item produces and whether the buffer can take them.
    assign emit_sum  = ex_flags_reg.has_col && ex_flags_reg.last_row;
    assign emit_zero = ex_flags_reg.last_col && ex_flags_reg.last_row;
    assign n_res     = {1'b0, emit_sum} + {1'b0, emit_zero};
    assign res_free  = RN'(RES_DEPTH) - res_cnt_reg;
    assign advance   = ex_valid_reg && (res_free >= RN'(n_res));
    assign load      = !q_stat.empty && (!ex_valid_reg || advance);
    assign q_pop     = load;
    assign ex_col    = ex_x_reg - CW'(1);

    // Column store: read when an item enters execute, written when it leaves.
    abs_dx_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (advance && ex_flags_reg.has_col),
        .wr_addr (ex_col),
        .wr_data (new_sum),
        .rd_en   (load && head_flags.has_col),
        .rd_addr (head_x - CW'(1)),
        .rd_data (store_rd)
    );

    // The first row starts each column afresh; later rows accumulate.
    assign new_sum = ex_flags_reg.first_row ? SUM_W'(ex_diff_reg)
                                            : store_rd + SUM_W'(ex_diff_reg);

    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        if (load)
        begin
            ex_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ex_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else
        begin
            ex_valid_reg <= ex_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ex_flags_reg <= head_flags;
            ex_x_reg     <= head_x;
            ex_diff_reg  <= head_diff;
        end
    end

    // The column sum goes first; the closing zero of the frame follows it.
    always_comb
    begin
        if (emit_sum)
        begin
            r0_idx  = ex_col;
            r0_sum  = new_sum;
            r0_last = 1'b0;
        end
        else
        begin
            r0_idx  = ex_x_reg;
            r0_sum  = '0;
            r0_last = 1'b1;
        end
    end

    // Result buffer pointers and count.
    assign res_pop = out_valid && !out_stall;

    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (advance)
        begin
            res_wr_next  = res_wr_reg + RP'(n_res);
            res_cnt_next = res_cnt_reg + RN'(n_res);
        end
        if (res_pop)
        begin
            res_rd_next  = res_rd_reg + RP'(1);
            res_cnt_next = res_cnt_next - RN'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            res_wr_reg  <= res_wr_next;
            res_rd_reg  <= res_rd_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (n_res != 2'd0))
        begin
            res_idx_reg[res_wr_reg]  <= r0_idx;
            res_sum_reg[res_wr_reg]  <= r0_sum;
            res_last_reg[res_wr_reg] <= r0_last;
        end
        if (advance && (n_res == 2'd2))
        begin
            res_idx_reg[res_wr_reg + RP'(1)]  <= ex_x_reg;
            res_sum_reg[res_wr_reg + RP'(1)]  <= '0;
            res_last_reg[res_wr_reg + RP'(1)] <= 1'b1;
        end
    end

    // Output request comes straight from the buffer head.
    assign out_valid    = (res_cnt_reg != '0);
    assign column_index = res_idx_reg[res_rd_reg];
    assign column_sum   = res_sum_reg[res_rd_reg];
    assign last         = res_last_reg[res_rd_reg];

endmodule

>>> rtl/abs_dx_column_sums_unit.sv
// Column sums of |p[x+1]-p[x]| over a grey frame's rows; one pixel per cycle unless stalled.
// A result request passes through the queue, the execute stage and the result buffer.
// Throughput is set by the column store, which does one read and one write per cycle.
// Reset clears counters, previous pixel and queues; width resets to 4096, height to 1.
// The column store is not cleared: the first row of every frame writes it.
// Depends on abs_dx_pkg, abs_dx_front, abs_dx_queue, abs_dx_back and abs_dx_ram.
module abs_dx_column_sums_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [abs_dx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abs_dx_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [abs_dx_pkg::PIX_W-1:0]         pixel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]         column_index,
    output logic [abs_dx_pkg::SUM_W-1:0]         column_sum,
    output logic                                 last
);

    import abs_dx_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int ITEM_W = $bits(abs_dx_flags_t) + CW + PIX_W;

    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_W_W-1:0] image_width_next;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [IMG_H_W-1:0] image_height_next;

    abs_dx_qstat_t      q_stat;
    logic               q_push;
    logic               q_pop;
    abs_dx_flags_t      f_flags;
    logic [CW-1:0]      f_x;
    logic [PIX_W-1:0]   f_diff;
    logic [ITEM_W-1:0]  q_head;
    abs_dx_flags_t      h_flags;
    logic [CW-1:0]      h_x;
    logic [PIX_W-1:0]   h_diff;

    // Configuration registers.
    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = cfg_data[IMG_H_W-1:0];
                default:          image_width_next  = image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_W'(4096);
            image_height_reg <= IMG_H_W'(1);
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Front end: position tracking and classification.
    abs_dx_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .item_flags   (f_flags),
        .item_x       (f_x),
        .item_diff    (f_diff)
    );

    // Queue between front and back.
    abs_dx_queue #(
        .DW (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_flags, f_x, f_diff}),
        .pop       (q_pop),
        .pop_data  (q_head),
        .stat      (q_stat)
    );

    assign {h_flags, h_x, h_diff} = q_head;

    // Back end: column store update and result buffering.
    abs_dx_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_flags   (h_flags),
        .head_x       (h_x),
        .head_diff    (h_diff),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .column_index (column_index),
        .column_sum   (column_sum),
        .last         (last)
    );

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("push into full queue");

    // The back never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // The closing result of a frame always carries a zero sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (column_sum == '0))
        else $error("frame end result with nonzero sum");

endmodule
